>>> sv/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds opcodes, status codes, controller states and controller/datapath structs.
// No dependencies.
package dq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 9;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 48;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE  = 1'b0,
        S_FETCH = 1'b1
    } dq_state_t;

    typedef struct packed {
        logic accept;
        logic fill;
    } dq_cmd_t;

    typedef struct packed {
        logic pop_ok;
        logic out_busy;
    } dq_stat_t;

endpackage

>>> sv/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the ring storage of the queue. No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/dq_ctrl.sv
// Controller state machine of the double-ended queue.
// Sequences input acceptance and the memory read of a pop; uses dq_pkg.
module dq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dq_pkg::dq_stat_t   stat,
    output dq_pkg::dq_cmd_t    cmd
);

    dq_pkg::dq_state_t state_reg;
    dq_pkg::dq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::S_IDLE: begin
                if (s_tvalid && s_tready && stat.pop_ok) begin
                    state_next = dq_pkg::S_FETCH;
                end
            end
            dq_pkg::S_FETCH: begin
                state_next = dq_pkg::S_IDLE;
            end
            default: begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.fill   = 1'b0;
        case (state_reg)
            dq_pkg::S_IDLE: begin
                s_tready   = !stat.out_busy;
                cmd.accept = s_tvalid && !stat.out_busy;
            end
            dq_pkg::S_FETCH: begin
                cmd.fill = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/dq_dp.sv
// Datapath of the double-ended queue: front index, count, ring addressing,
// slot RAM and result register. Uses dq_pkg and dq_ram.
module dq_dp #(
    parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [dq_pkg::OPCODE_W-1:0]     op_in,
    input  logic [dq_pkg::VALUE_W-1:0]      value_in,
    input  dq_pkg::dq_cmd_t                 cmd,
    output dq_pkg::dq_stat_t                stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dq_pkg::STATUS_W-1:0]     status_out,
    output logic [dq_pkg::VALUE_W-1:0]      popped_out,
    output logic [dq_pkg::COUNT_OUT_W-1:0]  count_out,
    output logic                            empty_out
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_X    = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] CAP_M1   = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_X) begin
            sum = sum - CAP_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0]               front_reg, front_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               count_m1;
    logic                           valid_reg, valid_next;
    logic [dq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [dq_pkg::VALUE_W-1:0]     popped_reg, popped_next;
    logic [dq_pkg::COUNT_OUT_W-1:0] cnt_out_reg, cnt_out_next;
    logic                           empty_reg, empty_next;

    logic                           full, empty, pop_ok;
    logic                           ram_we, ram_re;
    logic [IDX_W-1:0]               ram_waddr, ram_raddr;
    logic [dq_pkg::VALUE_W-1:0]     ram_rdata;
    dq_pkg::opcode_t                opcode;
    dq_pkg::status_t                res_status;

    dq_ram #(
        .WIDTH (dq_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign opcode        = dq_pkg::opcode_t'(op_in);
    assign full          = (count_reg == CAP_CNT);
    assign empty         = (count_reg == '0);
    assign count_m1      = count_reg - CNT_ONE;
    assign pop_ok        = op_in[1] && !empty;
    assign stat.pop_ok   = pop_ok;
    assign stat.out_busy = valid_reg && !m_tready;

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = front_reg;
        ram_raddr  = front_reg;
        res_status = dq_pkg::STAT_OK;
        case (opcode)
            dq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    res_status = dq_pkg::STAT_FULL;
                end else begin
                    front_next = ring_pos(front_reg, CAP_M1);
                    ram_waddr  = front_next;
                    ram_we     = cmd.accept;
                    count_next = count_reg + CNT_ONE;
                end
            end
            dq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    res_status = dq_pkg::STAT_FULL;
                end else begin
                    ram_waddr  = ring_pos(front_reg, count_reg[IDX_W-1:0]);
                    ram_we     = cmd.accept;
                    count_next = count_reg + CNT_ONE;
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    res_status = dq_pkg::STAT_EMPTY;
                end else begin
                    ram_raddr  = front_reg;
                    ram_re     = cmd.accept;
                    front_next = ring_pos(front_reg, IDX_ONE);
                    count_next = count_m1;
                end
            end
            dq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    res_status = dq_pkg::STAT_EMPTY;
                end else begin
                    ram_raddr  = ring_pos(front_reg, count_m1[IDX_W-1:0]);
                    ram_re     = cmd.accept;
                    count_next = count_m1;
                end
            end
            default: begin
                res_status = dq_pkg::STAT_OK;
            end
        endcase
        if (!cmd.accept) begin
            front_next = front_reg;
            count_next = count_reg;
        end
    end

    always_comb begin
        valid_next   = valid_reg && !m_tready;
        status_next  = status_reg;
        popped_next  = popped_reg;
        cnt_out_next = cnt_out_reg;
        empty_next   = empty_reg;
        if (cmd.accept) begin
            status_next  = res_status;
            popped_next  = '0;
            cnt_out_next = dq_pkg::COUNT_OUT_W'(count_next);
            empty_next   = (count_next == '0);
            valid_next   = !pop_ok;
        end
        if (cmd.fill) begin
            popped_next = ram_rdata;
            valid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        popped_reg  <= popped_next;
        cnt_out_reg <= cnt_out_next;
        empty_reg   <= empty_next;
    end

    assign m_tvalid   = valid_reg;
    assign status_out = status_reg;
    assign popped_out = popped_reg;
    assign count_out  = cnt_out_reg;
    assign empty_out  = empty_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("stored count exceeds capacity");

    a_fill_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill |-> !valid_reg)
        else $error("pop data arrives while result register is occupied");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && !op_in[1] && !full) |=> count_reg == $past(count_reg) + CNT_ONE)
        else $error("successful push did not advance count");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg != dq_pkg::STAT_OK) |-> popped_reg == '0)
        else $error("failed operation returned a nonzero value");
`endif

endmodule

>>> sv/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
// Joins dq_ctrl and dq_dp; uses dq_pkg.
//
//   channel | dir | handshake          | contents
//   s_      | in  | s_tvalid/s_tready  | tuser: opcode; tdata: value
//   m_      | out | m_tvalid/m_tready  | tuser: status; tdata: popped_value,
//           |     |                    |   item_count, is_empty
//
// A push or a pop on an empty queue writes its result register on acceptance; a successful pop
// goes through S_FETCH for the registered read of the slot RAM, and s_tready is low there.
// Every item yields one result, held in an output register until taken.
// A new item is accepted while the controller is idle and the output register is free or being drained.
// Reset clears the front index and count; the slot RAM is not cleared.
module double_ended_queue #(
    parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dq_pkg::OPCODE_W-1:0]   s_tuser,   // [1:0] opcode
    input  logic [dq_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dq_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    output logic [dq_pkg::M_TDATA_W-1:0]  m_tdata    // [31:0] popped_value, [40:32] item_count,
                                                     // [41] is_empty, [47:42] zero
);

    dq_pkg::dq_cmd_t                 cmd;
    dq_pkg::dq_stat_t                stat;
    logic [dq_pkg::VALUE_W-1:0]      popped;
    logic [dq_pkg::COUNT_OUT_W-1:0]  count;
    logic                            empty;

    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_in      (s_tuser),
        .value_in   (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .status_out (m_tuser),
        .popped_out (popped),
        .count_out  (count),
        .empty_out  (empty)
    );

    assign m_tdata = {6'b0, empty, count, popped};

endmodule

>>> dv/double_ended_queue_test.sv
// Self-checking testbench for the bounded double-ended queue (double_ended_queue).
// Drives opcode/value items, predicts each result with an in-bench ring model or a directed row,
// and compares each field; depends on dq_pkg and the RTL top level only.
module double_ended_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = dq_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        dq_pkg::status_t                status;
        logic [dq_pkg::VALUE_W-1:0]     popped;
        logic [dq_pkg::COUNT_OUT_W-1:0] count;
        logic                           empty;
    } dq_result_t;

    typedef struct packed {
        dq_pkg::opcode_t            op;
        logic [dq_pkg::VALUE_W-1:0] value;
        logic                       fixed;
        dq_result_t                 result;
    } dq_row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [dq_pkg::OPCODE_W-1:0]   s_tuser  = '0;   // [1:0] opcode
    logic [dq_pkg::S_TDATA_W-1:0]  s_tdata  = '0;   // [31:0] value
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dq_pkg::STATUS_W-1:0]   m_tuser;         // [1:0] status
    logic [dq_pkg::M_TDATA_W-1:0]  m_tdata;         // [31:0] popped_value, [40:32] item_count,
                                                    // [41] is_empty, [47:42] zero

    logic                          row_fixed = 1'b0;
    dq_result_t                    row_result = '0;

    logic [dq_pkg::VALUE_W-1:0]    ring_mem [CAPACITY];
    int                            ring_front = 0;
    int                            ring_count = 0;

    dq_result_t                    pending_results [$];
    int                            mismatch_count = 0;
    int                            quiet_cycles = 0;
    int                            src_idle = 0;
    int                            sink_idle = 0;
    logic                          hold_req = 1'b0;
    logic                          hold_taken = 1'b0;
    int                            hold_left = 0;

    dq_row_t                       directed_rows [18];

    double_ended_queue #(.CAPACITY(CAPACITY)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic dq_result_t deque_apply(dq_pkg::opcode_t op,
                                               logic [dq_pkg::VALUE_W-1:0] value);
        dq_result_t r;
        r = '0;
        r.status = dq_pkg::STAT_OK;
        case (op)
            dq_pkg::OP_PUSH_FRONT: begin
                if (ring_count >= CAPACITY) begin
                    r.status = dq_pkg::STAT_FULL;
                end else begin
                    ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
                    ring_mem[ring_front] = value;
                    ring_count++;
                end
            end
            dq_pkg::OP_PUSH_BACK: begin
                if (ring_count >= CAPACITY) begin
                    r.status = dq_pkg::STAT_FULL;
                end else begin
                    ring_mem[(ring_front + ring_count) % CAPACITY] = value;
                    ring_count++;
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (ring_count == 0) begin
                    r.status = dq_pkg::STAT_EMPTY;
                end else begin
                    r.popped = ring_mem[ring_front];
                    ring_front = (ring_front + 1) % CAPACITY;
                    ring_count--;
                end
            end
            default: begin
                if (ring_count == 0) begin
                    r.status = dq_pkg::STAT_EMPTY;
                end else begin
                    r.popped = ring_mem[(ring_front + ring_count - 1) % CAPACITY];
                    ring_count--;
                end
            end
        endcase
        r.count = dq_pkg::COUNT_OUT_W'(ring_count);
        r.empty = (ring_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [dq_pkg::VALUE_W-1:0] got,
                                   logic [dq_pkg::VALUE_W-1:0] want);
        $display("MISMATCH %s: got %h, want %h", field, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        dq_result_t got;
        dq_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status = dq_pkg::status_t'(m_tuser);
                got.popped = m_tdata[31:0];
                got.count  = m_tdata[40:32];
                got.empty  = m_tdata[41];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected item", {got.count, got.popped[22:0]}, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.popped !== want.popped)
                        report_mismatch("popped_value", got.popped, want.popped);
                    if (got.count !== want.count)
                        report_mismatch("item_count", 32'(got.count), 32'(want.count));
                    if (got.empty !== want.empty)
                        report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
                end
            end
            if (s_tvalid && s_tready) begin
                want = deque_apply(dq_pkg::opcode_t'(s_tuser), s_tdata);
                pending_results.push_back(row_fixed ? row_result : want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    task automatic send_item(dq_pkg::opcode_t op, logic [dq_pkg::VALUE_W-1:0] value,
                             logic fixed, dq_result_t result);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= value;
        row_fixed  <= fixed;
        row_result <= result;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [dq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(int n, int push_pct);
        dq_pkg::opcode_t op;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
            send_item(op, pick_value(), 1'b0, '0);
        end
    endtask

    task automatic run_sweep();
        for (int i = 0; i < CAPACITY + 4; i++)
            send_item($urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                      pick_value(), 1'b0, '0);
        for (int i = 0; i < CAPACITY + 6; i++)
            send_item($urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT,
                      pick_value(), 1'b0, '0);
    endtask

    initial begin
        directed_rows = '{
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
              '{dq_pkg::STAT_EMPTY, 32'h0000_0000, 9'd0, 1'b1}},
            '{dq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1,
              '{dq_pkg::STAT_EMPTY, 32'h0000_0000, 9'd0, 1'b1}},
            '{dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
              '{dq_pkg::STAT_OK,    32'h0000_0000, 9'd1, 1'b0}},
            '{dq_pkg::OP_PUSH_BACK,  32'h8000_0000, 1'b1,
              '{dq_pkg::STAT_OK,    32'h0000_0000, 9'd2, 1'b0}},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
              '{dq_pkg::STAT_OK,    32'h7FFF_FFFF, 9'd1, 1'b0}},
            '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1,
              '{dq_pkg::STAT_OK,    32'h8000_0000, 9'd0, 1'b1}},
            '{dq_pkg::OP_POP_BACK,   32'h1234_5678, 1'b1,
              '{dq_pkg::STAT_EMPTY, 32'h0000_0000, 9'd0, 1'b1}},
            '{dq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
              '{dq_pkg::STAT_OK,    32'h0000_0000, 9'd1, 1'b0}},
            '{dq_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
            '{dq_pkg::OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
            '{dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
            '{dq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b0, '0},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
            '{dq_pkg::OP_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle  = 13;
        sink_idle <= 50;
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].fixed, directed_rows[i].result);
        run_random(160, 65);
        run_random(160, 35);

        src_idle  = 50;
        sink_idle <= 13;
        hold_req  <= 1'b1;
        run_random(160, 50);

        src_idle  = 0;
        sink_idle <= 0;
        run_random(100, 80);
        run_sweep();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
